// File: design/abd_pkg.sv
// shared types and constants for the ascii bit stream deframer
package abd_pkg;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharOne  = 8'h31;

  localparam logic [2:0] KindSync1   = 3'd0;
  localparam logic [2:0] KindSync2   = 3'd1;
  localparam logic [2:0] KindLength  = 3'd2;
  localparam logic [2:0] KindPayload = 3'd3;
  localparam logic [2:0] KindError   = 3'd4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic       frame_last;
  } out_t;

  typedef enum logic [1:0] {
    TOK_BIT0,
    TOK_BIT1,
    TOK_EOS
  } tok_e;

  typedef struct packed {
    logic valid;
    tok_e tok;
  } tok_req_t;

endpackage

// File: design/ascii_bit_stream_deframer.sv
// top level of the ascii bit stream deframer
// Takes one character per transaction and accepts one every cycle while the token queue
// has room. '0' and '1' characters become bits, assembled MSB first into bytes; each sync,
// length and payload byte is reported as it completes, and an end-of-stream transaction
// before the frame is complete reports one error. A result reaches the output register via
// the token queue (queue write at acceptance, then the deframer step once the token is at
// the queue head); the deframer retires one queued token per cycle, so sustained rate is
// one character per cycle whenever the output side keeps taking results.
module ascii_bit_stream_deframer #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  abd_pkg::in_t  in_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output abd_pkg::out_t out_data_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);

  abd_pkg::tok_req_t push;
  logic              full;
  logic              tok_valid;
  abd_pkg::tok_e     tok;
  logic              tok_pop;

  abd_front u_front (
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .full_i     (full)
  );

  abd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .pop_valid_o (tok_valid),
    .pop_tok_o   (tok),
    .pop_i       (tok_pop)
  );

  abd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

// File: design/abd_front.sv
// front end: classifies input characters into bit and end tokens
module abd_front (
  input  abd_pkg::in_t     in_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output abd_pkg::tok_req_t push_o,
  input  logic             full_i
);

  logic is_bit;

  assign in_ready_o = !full_i;
  assign is_bit = (in_data_i.char_code == abd_pkg::CharZero) ||
                  (in_data_i.char_code == abd_pkg::CharOne);

  always_comb begin
    push_o.valid = in_valid_i && !full_i && (in_data_i.end_of_stream || is_bit);
    priority if (in_data_i.end_of_stream) begin
      push_o.tok = abd_pkg::TOK_EOS;
    end else if (in_data_i.char_code == abd_pkg::CharOne) begin
      push_o.tok = abd_pkg::TOK_BIT1;
    end else begin
      push_o.tok = abd_pkg::TOK_BIT0;
    end
  end

endmodule

// File: design/abd_fifo.sv
// short token queue between front end and deframer
module abd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  abd_pkg::tok_req_t push_i,
  output logic              full_o,
  output logic              pop_valid_o,
  output abd_pkg::tok_e     pop_tok_o,
  input  logic              pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  abd_pkg::tok_e mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic push, pop;

  assign full_o      = count_q == CntW'(Depth);
  assign pop_valid_o = count_q != '0;
  assign pop_tok_o   = mem_q[rd_ptr_q];
  assign push        = push_i.valid;
  assign pop         = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: design/abd_back.sv
// back end: assembles bytes, tracks frame phase and holds the output register
module abd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_valid_i,
  input  abd_pkg::tok_e tok_i,
  output logic          tok_pop_o,
  output abd_pkg::out_t out_data_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_LEN,
    PH_PAYLOAD,
    PH_DONE
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [7:0]    shift_q, shift_d;
  logic [2:0]    bit_cnt_q, bit_cnt_d;
  logic [7:0]    len_q, len_d;
  logic [7:0]    pay_cnt_q, pay_cnt_d;
  abd_pkg::out_t out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    shift_nx;
  logic [7:0]    pay_cnt_nx;
  logic          take;

  assign take        = tok_valid_i && (!out_valid_q || out_ready_i);
  assign tok_pop_o   = take;
  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;
  assign shift_nx    = {shift_q[6:0], tok_i == abd_pkg::TOK_BIT1};
  assign pay_cnt_nx  = pay_cnt_q + 8'd1;

  always_comb begin
    phase_d     = phase_q;
    shift_d     = shift_q;
    bit_cnt_d   = bit_cnt_q;
    len_d       = len_q;
    pay_cnt_d   = pay_cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take) begin
      if (tok_i == abd_pkg::TOK_EOS) begin
        phase_d   = PH_SYNC1;
        shift_d   = '0;
        bit_cnt_d = '0;
        len_d     = '0;
        pay_cnt_d = '0;
        if (phase_q != PH_DONE) begin
          out_valid_d      = 1'b1;
          out_d.kind       = abd_pkg::KindError;
          out_d.byte_value = '0;
          out_d.frame_last = 1'b0;
        end
      end else if (phase_q != PH_DONE) begin
        if (bit_cnt_q != 3'd7) begin
          shift_d   = shift_nx;
          bit_cnt_d = bit_cnt_q + 3'd1;
        end else begin
          shift_d          = '0;
          bit_cnt_d        = '0;
          out_valid_d      = 1'b1;
          out_d.byte_value = shift_nx;
          out_d.frame_last = 1'b0;
          unique case (phase_q)
            PH_SYNC1: begin
              phase_d    = PH_SYNC2;
              out_d.kind = abd_pkg::KindSync1;
            end
            PH_SYNC2: begin
              phase_d    = PH_LEN;
              out_d.kind = abd_pkg::KindSync2;
            end
            PH_LEN: begin
              len_d      = shift_nx;
              pay_cnt_d  = '0;
              out_d.kind = abd_pkg::KindLength;
              if (shift_nx == 8'd0) begin
                phase_d          = PH_DONE;
                out_d.frame_last = 1'b1;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
            default: begin
              pay_cnt_d  = pay_cnt_nx;
              out_d.kind = abd_pkg::KindPayload;
              if (pay_cnt_nx == len_q) begin
                phase_d          = PH_DONE;
                out_d.frame_last = 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC1;
      shift_q     <= '0;
      bit_cnt_q   <= '0;
      len_q       <= '0;
      pay_cnt_q   <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      bit_cnt_q   <= bit_cnt_d;
      len_q       <= len_d;
      pay_cnt_q   <= pay_cnt_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
